// ----- hw/rtl/cgc_pkg.sv -----
// Shared types, constants and helper functions for the Clebsch-Gordan coefficient unit.
`timescale 1ns / 1ps

package cgc_pkg;

  // Largest angular momentum that is accepted.
  localparam int MAX_L = 6;
  localparam logic signed [5:0] MAX_L_S = 6'(MAX_L);

  // Factorial arguments: the first NUM_FACTS build the numerator, the rest the denominator.
  localparam int NUM_FACTS = 6;
  localparam int FACTS     = 10;

  // Width of the exact integers for the numerator and denominator products.
  localparam int WIDE_W = 96;

  // Pascal triangle limits, with rows up to 2 * MAX_L.
  localparam int BIN_N = 2 * MAX_L + 1;
  localparam int BIN_W = 10;

  localparam logic [31:0] Q_ONE = 32'h4000_0000;

  typedef logic [4:0] fact_arg_t;

  // Item as classified by the front end.
  typedef struct packed {
    logic                        bad;
    logic                        mode;
    logic                        flip;
    logic [3:0]                  n1;
    logic [3:0]                  n2;
    logic [3:0]                  n3;
    logic [3:0]                  a;
    logic [3:0]                  b;
    logic [3:0]                  kmax;
    logic [3:0]                  num_init;
    fact_arg_t [FACTS-1:0]       fargs;
  } cgc_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_G1,
    S_G2,
    S_GEND,
    S_FACT,
    S_HORN,
    S_DIV,
    S_SQRT,
    S_FIN,
    S_DONE
  } cgc_state_t;

  typedef logic [BIN_N-1:0][BIN_N-1:0][BIN_W-1:0] binom_tab_t;

  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n < BIN_N; n++) begin
      t[n][0] = BIN_W'(1);
      for (int k = 1; k <= n; k++) begin
        if (k <= n - 1) begin
          t[n][k] = t[n-1][k-1] + t[n-1][k];
        end else begin
          t[n][k] = t[n-1][k-1];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

  // Binomial coefficient; an index outside the triangle gives zero.
  function automatic logic [BIN_W-1:0] binom_f(input logic [3:0] n, input logic signed [5:0] k);
    logic [BIN_W-1:0] v;
    v = '0;
    if (k >= 0 && k <= signed'({2'b00, n}) && n < 4'(BIN_N)) begin
      v = BINOM[n][k[3:0]];
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/cgc_front.sv -----
// Front end: checks the selection rules, derives the summation limits and queues requests.
`timescale 1ns / 1ps

module cgc_front
  import cgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_mode,
  input  logic [2:0]       in_ja,
  input  logic signed [3:0] in_ma,
  input  logic [2:0]       in_jb,
  input  logic signed [3:0] in_mb,
  input  logic [2:0]       in_jc,
  input  logic signed [3:0] in_mc,
  input  logic             q_pop,
  output logic             q_empty,
  output cgc_item_t        q_item
);

  cgc_item_t        cls;
  cgc_item_t        mem [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push_ok;

  logic signed [5:0] l1, l2, l3, m1, m2, mc6, m3, par;
  logic signed [5:0] am1, am2, am3, dl, adl, ka, kb;

  always_comb begin
    l1  = signed'({3'b000, in_ja});
    l2  = signed'({3'b000, in_jb});
    l3  = signed'({3'b000, in_jc});
    m1  = {{2{in_ma[3]}}, in_ma};
    m2  = {{2{in_mb[3]}}, in_mb};
    mc6 = {{2{in_mc[3]}}, in_mc};
    m3  = in_mode ? -mc6 : mc6;
    am1 = (m1 < 0) ? -m1 : m1;
    am2 = (m2 < 0) ? -m2 : m2;
    am3 = (m3 < 0) ? -m3 : m3;
    dl  = l1 - l2;
    adl = (dl < 0) ? -dl : dl;
    par = l1 - l2 - mc6;
    ka  = l1 - m1;
    kb  = l2 + m2;

    cls.bad = (l1 > MAX_L_S) || (l2 > MAX_L_S) || (l3 > MAX_L_S) ||
              (l3 < adl) || (l3 > l1 + l2) || (m3 != m1 + m2) ||
              (am1 > l1) || (am2 > l2) || (am3 > l3);
    cls.mode     = in_mode;
    cls.flip     = in_mode & par[0];
    cls.n1       = 4'(l1 + l2 - l3);
    cls.n2       = 4'(l1 - l2 + l3);
    cls.n3       = 4'(l2 + l3 - l1);
    cls.a        = 4'(ka);
    cls.b        = 4'(kb);
    cls.kmax     = (ka < kb) ? 4'(ka) : 4'(kb);
    cls.num_init = in_mode ? 4'd1 : 4'(2 * l3 + 6'sd1);
    cls.fargs[0] = 5'(l1 + m1);
    cls.fargs[1] = 5'(l1 - m1);
    cls.fargs[2] = 5'(l2 + m2);
    cls.fargs[3] = 5'(l2 - m2);
    cls.fargs[4] = 5'(l3 + m3);
    cls.fargs[5] = 5'(l3 - m3);
    cls.fargs[6] = 5'(l1 + l2 - l3);
    cls.fargs[7] = 5'(l1 - l2 + l3);
    cls.fargs[8] = 5'(l2 + l3 - l1);
    cls.fargs[9] = 5'(l1 + l2 + l3 + 6'sd1);
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_item  = mem[rd_ptr_r];
  assign push_ok = in_push && !in_full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && !q_empty);
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(q_pop && !q_empty);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // The two-entry queue can never hold more than two requests.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("request queue count out of range");

endmodule

// ----- hw/rtl/cgc_back.sv -----
// Back end: sequencer for the binomial sum, exact factorial ratio, division and square root.
`timescale 1ns / 1ps

module cgc_back
  import cgc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cgc_item_t          q_item,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_coefficient,
  output logic               out_status
);

  cgc_state_t          state_r, state_nxt;
  cgc_item_t           it_r, it_nxt;
  logic [3:0]          k_r, k_nxt;
  logic [19:0]         t12_r, t12_nxt;
  logic [BIN_W-1:0]    b3_r, b3_nxt;
  logic signed [35:0]  acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic [63:0]         g2_r, g2_nxt;
  logic [WIDE_W-1:0]   num_r, num_nxt;
  logic [WIDE_W-1:0]   den_r, den_nxt;
  logic [3:0]          j_r, j_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [WIDE_W-1:0]   prod_r, prod_nxt;
  logic [3:0]          dig_r, dig_nxt;
  logic [WIDE_W:0]     rem_r, rem_nxt;
  logic [62:0]         y_r, y_nxt;
  logic [5:0]          dcnt_r, dcnt_nxt;
  logic [31:0]         r_r, r_nxt;
  logic [4:0]          sb_r, sb_nxt;
  logic [31:0]         res_coef_r, res_coef_nxt;
  logic                res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_coef_r, out_coef_nxt;
  logic                out_status_r, out_status_nxt;

  logic                slot_free;
  logic [29:0]         term;
  logic [35:0]         acc_abs;
  logic [31:0]         ag;
  fact_arg_t           fcur;
  logic [WIDE_W-1:0]   horner;
  logic [WIDE_W:0]     rem_sub;
  logic                ge;
  logic [31:0]         trial;
  logic [63:0]         sq;
  logic [32:0]         rnd;
  logic [31:0]         qv;

  assign slot_free       = !out_valid_r || out_pop;
  assign out_empty       = !out_valid_r;
  assign out_coefficient = signed'(out_coef_r);
  assign out_status      = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    it_nxt         = it_r;
    k_nxt          = k_r;
    t12_nxt        = t12_r;
    b3_nxt         = b3_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    g2_nxt         = g2_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    dig_nxt        = dig_r;
    rem_nxt        = rem_r;
    y_nxt          = y_r;
    dcnt_nxt       = dcnt_r;
    r_nxt          = r_r;
    sb_nxt         = sb_r;
    res_coef_nxt   = res_coef_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    out_coef_nxt   = out_coef_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;

    term    = 30'(t12_r * b3_r);
    acc_abs = (acc_r < 0) ? 36'(-acc_r) : 36'(acc_r);
    ag      = acc_abs[31:0];
    fcur    = it_r.fargs[j_r];
    horner  = WIDE_W'({prod_r[WIDE_W-5:0], 4'b0000}) + WIDE_W'(num_r * g2_r[63:60]);
    ge      = rem_r >= {1'b0, den_r};
    rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    trial   = r_r | (32'd1 << sb_r);
    sq      = trial * trial;
    rnd     = ({1'b0, r_r} + 33'd1) >> 1;
    qv      = (rnd > {1'b0, Q_ONE}) ? Q_ONE : rnd[31:0];

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          it_nxt = q_item;
          k_nxt  = 4'd0;
          acc_nxt = '0;
          if (q_item.bad) begin
            res_coef_nxt   = '0;
            res_status_nxt = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_G1;
          end
        end
      end
      S_G1: begin
        t12_nxt = 20'(binom_f(it_r.n1, signed'({2'b00, k_r})) *
                      binom_f(it_r.n2, signed'({2'b00, it_r.a}) - signed'({2'b00, k_r})));
        b3_nxt  = binom_f(it_r.n3, signed'({2'b00, it_r.b}) - signed'({2'b00, k_r}));
        state_nxt = S_G2;
      end
      S_G2: begin
        acc_nxt = k_r[0] ? (acc_r - signed'({6'b0, term})) : (acc_r + signed'({6'b0, term}));
        if (k_r == it_r.kmax) begin
          state_nxt = S_GEND;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = S_G1;
        end
      end
      S_GEND: begin
        if (acc_r == 0) begin
          res_coef_nxt   = '0;
          res_status_nxt = 1'b0;
          state_nxt      = S_DONE;
        end else begin
          neg_nxt   = (acc_r < 0) ^ it_r.flip;
          g2_nxt    = ag * ag;
          num_nxt   = WIDE_W'(it_r.num_init);
          den_nxt   = WIDE_W'(1);
          j_nxt     = 4'd0;
          cnt_nxt   = 5'd2;
          state_nxt = S_FACT;
        end
      end
      S_FACT: begin
        // Each factorial is built by multiplying in 2, 3, ... up to its argument.
        if (cnt_r <= fcur) begin
          if (j_r < 4'(NUM_FACTS)) begin
            num_nxt = WIDE_W'(num_r * cnt_r);
          end else begin
            den_nxt = WIDE_W'(den_r * cnt_r);
          end
          cnt_nxt = cnt_r + 5'd1;
        end else if (j_r == 4'(FACTS - 1)) begin
          prod_nxt  = '0;
          dig_nxt   = 4'd0;
          state_nxt = S_HORN;
        end else begin
          j_nxt   = j_r + 4'd1;
          cnt_nxt = 5'd2;
        end
      end
      S_HORN: begin
        // Numerator times G squared, one hex digit of G squared per cycle.
        prod_nxt = horner;
        g2_nxt   = {g2_r[59:0], 4'b0000};
        dig_nxt  = dig_r + 4'd1;
        if (dig_r == 4'd15) begin
          rem_nxt   = {1'b0, horner};
          y_nxt     = '0;
          dcnt_nxt  = 6'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring division; the first quotient bit is the integer part.
        y_nxt    = {y_r[61:0], ge};
        rem_nxt  = {rem_sub[WIDE_W-1:0], 1'b0};
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd62) begin
          r_nxt     = '0;
          sb_nxt    = 5'd31;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq <= {1'b0, y_r}) begin
          r_nxt = trial;
        end
        sb_nxt = sb_r - 5'd1;
        if (sb_r == 5'd0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // r is floor(2 * value), so (r + 1) / 2 rounds to nearest with ties upward.
        res_coef_nxt   = neg_r ? (32'd0 - qv) : qv;
        res_status_nxt = 1'b0;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_coef_nxt   = res_coef_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r         <= it_nxt;
    k_r          <= k_nxt;
    t12_r        <= t12_nxt;
    b3_r         <= b3_nxt;
    acc_r        <= acc_nxt;
    neg_r        <= neg_nxt;
    g2_r         <= g2_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    j_r          <= j_nxt;
    cnt_r        <= cnt_nxt;
    prod_r       <= prod_nxt;
    dig_r        <= dig_nxt;
    rem_r        <= rem_nxt;
    y_r          <= y_nxt;
    dcnt_r       <= dcnt_nxt;
    r_r          <= r_nxt;
    sb_r         <= sb_nxt;
    res_coef_r   <= res_coef_nxt;
    res_status_r <= res_status_nxt;
    out_coef_r   <= out_coef_nxt;
    out_status_r <= out_status_nxt;
  end

  // A request is taken from the queue only by an idle sequencer and only when one waits.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && !q_empty)
    else $error("queue popped outside idle state");

  // A finished result waits while the output register is still occupied.
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_pop |=> (state_r == S_DONE))
    else $error("result overwrote an unread output");

  // A rule violation always reports a zero coefficient.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && res_status_r |-> (res_coef_r == 32'd0))
    else $error("nonzero coefficient with status set");

endmodule

// ----- hw/rtl/clebsch_gordan_coefficient_unit_core.sv -----
// Top level of the Clebsch-Gordan coefficient unit: front end, request queue and sequencer.
`timescale 1ns / 1ps

// Each request gives l1, m1, l2, m2, l3, m3 and a mode (0 Clebsch-Gordan, 1 Wigner 3j) and
// yields one signed Q1.30 value, rounded to nearest, with status 1 and value 0 when a selection
// rule fails. The front end checks the rules and holds up to two requests in a queue, so it
// keeps taking requests while the sequencer works. The sequencer takes one request at a time:
// a rule violation goes straight to the result; otherwise it sums the binomial terms (up to 13),
// builds the ten factorials one factor at a time, multiplies by G squared one hex digit at a
// time, then runs the bit-serial division and the bit-serial square root.

module clebsch_gordan_coefficient_unit_core
  import cgc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_mode,
  input  logic [2:0]         in_ja,
  input  logic signed [3:0]  in_ma,
  input  logic [2:0]         in_jb,
  input  logic signed [3:0]  in_mb,
  input  logic [2:0]         in_jc,
  input  logic signed [3:0]  in_mc,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_coefficient,
  output logic               out_status
);

  cgc_item_t q_item;
  logic      q_empty;
  logic      q_pop;

  cgc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_mode (in_mode),
    .in_ja   (in_ja),
    .in_ma   (in_ma),
    .in_jb   (in_jb),
    .in_mb   (in_mb),
    .in_jc   (in_jc),
    .in_mc   (in_mc),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  cgc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_coefficient (out_coefficient),
    .out_status      (out_status)
  );

endmodule

// ----- test/clebsch_gordan_coefficient_unit_core_test.sv -----
// Self-checking testbench for the Clebsch-Gordan / Wigner 3j coefficient unit.
`timescale 1ns / 1ps

module clebsch_gordan_coefficient_unit_core_test;
  import cgc_pkg::*;

  typedef logic [511:0] big_t;

  typedef struct {
    logic              mode;
    logic [2:0]        ja;
    logic signed [3:0] ma;
    logic [2:0]        jb;
    logic signed [3:0] mb;
    logic [2:0]        jc;
    logic signed [3:0] mc;
  } cg_req_t;

  typedef struct {
    logic signed [31:0] coefficient;
    logic               status;
  } cg_coeff_t;

  class cg_scoreboard;
    cg_coeff_t expected_coeffs[$];
    int        errors = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function big_t fact_big(int n);
      big_t r;
      r = 1;
      for (int i = 2; i <= n; i++) r = r * i;
      return r;
    endfunction

    function longint choose(int n, int k);
      longint unsigned r;
      r = 1;
      if (n < 0 || k < 0 || k > n) return 0;
      for (int i = 0; i < k; i++) r = r * longint'(n - i) / longint'(i + 1);
      return longint'(r);
    endfunction

    function cg_coeff_t coupling_value(cg_req_t rq);
      cg_coeff_t res;
      int l1, l2, l3, m1, m2, m3, m3in, kmax, dl;
      longint g, term, ag, lo, hi, mid, q;
      logic neg;
      big_t p, d, t;
      l1 = rq.ja; l2 = rq.jb; l3 = rq.jc;
      m1 = rq.ma; m2 = rq.mb; m3in = rq.mc;
      m3 = rq.mode ? -m3in : m3in;
      dl = (l1 > l2) ? l1 - l2 : l2 - l1;
      res.coefficient = 0;
      res.status = 1'b1;
      if (l1 > MAX_L || l2 > MAX_L || l3 > MAX_L || l3 < dl || l3 > l1 + l2 ||
          m3 != m1 + m2 || m1 > l1 || -m1 > l1 || m2 > l2 || -m2 > l2 ||
          m3 > l3 || -m3 > l3) return res;
      res.status = 1'b0;
      kmax = ((l1 - m1) < (l2 + m2)) ? (l1 - m1) : (l2 + m2);
      g = 0;
      for (int k = 0; k <= kmax; k++) begin
        term = choose(l1 + l2 - l3, k) * choose(l1 - l2 + l3, l1 - m1 - k) *
               choose(-l1 + l2 + l3, l2 + m2 - k);
        g = (k % 2 == 1) ? g - term : g + term;
      end
      if (g == 0) return res;
      neg = g < 0;
      ag = neg ? -g : g;
      // The 3j phase (-1)^(l1-l2-m3) depends only on the parity.
      if (rq.mode && (((l1 - l2 - m3in) % 2) != 0)) neg = !neg;
      p = rq.mode ? big_t'(1) : big_t'(2 * l3 + 1);
      p = p * fact_big(l1 + m1) * fact_big(l1 - m1) * fact_big(l2 + m2) *
          fact_big(l2 - m2) * fact_big(l3 + m3) * fact_big(l3 - m3);
      p = (p * ag * ag) << 60;
      d = fact_big(l1 + l2 - l3) * fact_big(l1 - l2 + l3) * fact_big(-l1 + l2 + l3) *
          fact_big(l1 + l2 + l3 + 1);
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        t = d * mid * mid;
        if (t <= p) lo = mid;
        else hi = mid - 1;
      end
      q = lo;
      if (q < (64'd1 << 30)) begin
        t = d * (2 * q + 1) * (2 * q + 1);
        if ((p << 2) >= t) q++;
      end
      res.coefficient = neg ? -32'(q) : 32'(q);
      return res;
    endfunction

    function void note_request(cg_req_t rq);
      expected_coeffs.push_back(coupling_value(rq));
    endfunction

    task check_result(logic signed [31:0] coef, logic st);
      cg_coeff_t e;
      if (expected_coeffs.size() == 0) begin
        report($sformatf("unexpected result coef=%0d status=%0b", coef, st));
      end else begin
        e = expected_coeffs.pop_front();
        if (coef !== e.coefficient)
          report($sformatf("coefficient %0d, expected %0d", coef, e.coefficient));
        if (st !== e.status)
          report($sformatf("status %0b, expected %0b", st, e.status));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic              in_mode;
  logic [2:0]        in_ja;
  logic signed [3:0] in_ma;
  logic [2:0]        in_jb;
  logic signed [3:0] in_mb;
  logic [2:0]        in_jc;
  logic signed [3:0] in_mc;
  logic              out_empty;
  logic              out_pop;
  logic signed [31:0] out_coefficient;
  logic              out_status;

  cg_scoreboard sb = new();
  logic quiet = 1'b0;

  clebsch_gordan_coefficient_unit_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  task send_request(cg_req_t rq);
    in_push <= 1'b1;
    in_mode <= rq.mode;
    in_ja <= rq.ja; in_ma <= rq.ma;
    in_jb <= rq.jb; in_mb <= rq.mb;
    in_jc <= rq.jc; in_mc <= rq.mc;
    do @(posedge clk); while (in_full);
    sb.note_request(rq);
  endtask

  task pause_sender();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function cg_req_t mk(int mode, int a, int ma, int b, int mb, int c, int mc);
    cg_req_t r;
    r.mode = mode[0]; r.ja = a[2:0]; r.ma = ma[3:0];
    r.jb = b[2:0]; r.mb = mb[3:0]; r.jc = c[2:0]; r.mc = mc[3:0];
    return r;
  endfunction

  // Mostly physical requests; some with one field disturbed, some pure noise.
  function cg_req_t random_request();
    cg_req_t r;
    int l1, l2, l3, m1, m2, lo3, hi3, kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      r = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      return r;
    end
    l1 = $urandom_range(0, MAX_L);
    l2 = $urandom_range(0, MAX_L);
    lo3 = (l1 > l2) ? l1 - l2 : l2 - l1;
    hi3 = (l1 + l2 > MAX_L) ? MAX_L : l1 + l2;
    l3 = $urandom_range(lo3, hi3);
    do begin
      m1 = int'($urandom_range(0, 2 * l1)) - l1;
      m2 = int'($urandom_range(0, 2 * l2)) - l2;
    end while (m1 + m2 > l3 || m1 + m2 < -l3);
    r = mk($urandom_range(0, 1), l1, m1, l2, m2, l3, 0);
    r.mc = r.mode ? 4'(-(m1 + m2)) : 4'(m1 + m2);
    if (kind == 1) begin
      case ($urandom_range(0, 3))
        0: r.mc = r.mc ^ 4'($urandom_range(1, 15));
        1: r.jc = 3'($urandom);
        2: r.ma = 4'($urandom);
        default: r.ja = 3'(7);
      endcase
    end
    return r;
  endfunction

  initial begin
    cg_req_t directed[$];
    rst_n = 1'b0;
    in_push = 1'b0;
    in_mode = 1'b0;
    in_ja = '0; in_ma = '0; in_jb = '0; in_mb = '0; in_jc = '0; in_mc = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{mk(0, 0, 0, 0, 0, 0, 0), mk(1, 0, 0, 0, 0, 0, 0),
                 mk(0, 6, 6, 6, 6, 6, 0), mk(0, 6, 6, 6, -6, 6, 0),
                 mk(1, 6, -6, 6, 6, 6, 0), mk(0, 6, 6, 6, 6, 12, 12),
                 mk(0, 3, 3, 3, 3, 6, 6), mk(1, 3, 3, 3, 3, 6, -6),
                 mk(0, 1, 0, 1, 0, 1, 0), mk(1, 1, 0, 1, 0, 1, 0),
                 mk(0, 2, 1, 1, -1, 5, 0), mk(0, 2, 1, 1, 0, 2, 2),
                 mk(0, 7, 0, 0, 0, 7, 0), mk(0, 0, 0, 7, 0, 7, 0),
                 mk(0, 2, 3, 1, -3, 1, 0), mk(0, 1, -8, 1, 7, 0, -1),
                 mk(1, 2, 1, 1, 0, 3, 1), mk(1, 2, 1, 1, 0, 3, -1),
                 mk(0, 6, 0, 6, 0, 0, 0), mk(1, 6, 0, 6, 0, 0, 0),
                 mk(0, 4, -2, 5, 3, 3, 1), mk(1, 5, 2, 4, -3, 6, 1)};
    foreach (directed[i]) begin
      send_request(directed[i]);
      pause_sender();
    end
    // Hold off until the unit has drained completely.
    in_push <= 1'b0;
    while (sb.expected_coeffs.size() != 0) @(posedge clk);

    for (int i = 0; i < 750; i++) begin
      if (i == 650) quiet = 1'b1;
      send_request(random_request());
      pause_sender();
    end
    in_push <= 1'b0;
    while (sb.expected_coeffs.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.expected_coeffs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: pop with random stall bursts, none once the run goes quiet.
  initial begin
    int stall;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_result(out_coefficient, out_status);
      if (quiet) begin
        out_pop <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 5);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

endmodule
